/* src/nupm_pkg.sv */
// ----------------------------------------------------------------------------
// nupm_pkg: shared types and constants for the nearest unused palette match
// Request codes carried in tuser, field widths and the distance width.
// ----------------------------------------------------------------------------
`default_nettype none

package nupm_pkg;

  // Request kinds carried in the slave-side tuser
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_MATCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned OUT_DATA_W = 32;

  // Sum of three 8-bit squares fits in 18 bits
  localparam int unsigned DIST_W = 18;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DIST_W-1:0]  dist_t;

endpackage

`default_nettype wire

/* src/nearest_unused_palette_match.sv */
// ----------------------------------------------------------------------------
// nearest_unused_palette_match: nearest unused palette color lookup
// Palette memory with one used mark per entry; each match picks the closest
// unused entry by squared RGB distance, marks it and returns it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser = request kind (load, match, clear); tdata carries
//   the slot and color of a load and the pixel of a match. Master channel:
//   one transaction per match with the chosen color and slot in tdata and
//   the wrap flag in tuser. Loads, clears and unknown kinds give nothing.
//   cfg_wr_en_i writes the number of active slots (0 acts as 1, values
//   above PALETTE_DEPTH act as PALETTE_DEPTH); write it only while idle.
//   A load or clear completes as it is accepted in the idle state. A match
//   scans the active slots with one palette memory read per cycle (single
//   read port), then passes the read, distance and compare registers and
//   commits in the finish state into the result register.
//   Throughput: one item at a time; the next item is accepted once the
//   previous one is committed, even if its result has not been taken yet.
//   Receiver stall: a finished match waits in the commit state until the
//   output register is free; the output holds until tready.
//   Reset: all used marks clear, active slots = 64, palette contents stay
//   undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_unused_palette_match
  import nupm_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration: active slot count
  input  wire logic                  cfg_wr_en_i,
  input  wire logic [CFG_W-1:0]      cfg_wr_data_i,
  // Request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [5:0] entry_index, [29:6] entry_color, [37:30] pixel_red,
  // [45:38] pixel_green, [53:46] pixel_blue, [55:54] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]            s_axis_tuser,
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [23:0] match_color, [29:24] match_index, [31:30] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // [0] marks_wrapped
  output logic                       m_axis_tuser
);

  localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // Input field split
  logic [SLOT_W-1:0] in_slot;
  color_t            in_color;
  logic [CHAN_W-1:0] in_red, in_green, in_blue;

  assign in_slot  = s_axis_tdata[5:0];
  assign in_color = s_axis_tdata[29:6];
  assign in_red   = s_axis_tdata[37:30];
  assign in_green = s_axis_tdata[45:38];
  assign in_blue  = s_axis_tdata[53:46];

  state_e state_q, state_d;

  logic [CFG_W-1:0]         cfg_entries_q;
  logic [PALETTE_DEPTH-1:0] used_q, used_d;

  logic [CHAN_W-1:0] pix_red_q, pix_green_q, pix_blue_q;
  logic [IDX_W-1:0]  last_idx_q, last_idx;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;

  // Read stage (aligned with memory read data)
  logic              s1_valid_q, s1_valid_d;
  logic              s1_last_q, s1_used_q;
  logic [IDX_W-1:0]  s1_idx_q;
  color_t            rd_data_q;

  // Distance stage
  logic              s2_valid_q, s2_last_q, s2_used_q;
  logic [IDX_W-1:0]  s2_idx_q;
  color_t            s2_color_q;
  dist_t             s2_dist_q;
  dist_t             entry_dist;

  // Running best among unused entries and among all entries
  logic              found_free_q, found_all_q;
  dist_t             free_dist_q, all_dist_q;
  logic [IDX_W-1:0]  free_idx_q, all_idx_q;
  color_t            free_color_q, all_color_q;
  logic              take_free, take_all;

  // Output register
  logic              out_valid_q;
  color_t            out_color_q;
  logic [SLOT_W-1:0] out_idx_q;
  logic              out_wrap_q;

  logic              in_fire, out_free, commit, wrapped;
  logic              load_we;
  logic [IDX_W-1:0]  load_idx, pick_idx;
  color_t            pick_color;

  // Palette memory
  color_t mem [PALETTE_DEPTH];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Clamp the active slot count to a last scan index
  always_comb begin
    if (cfg_entries_q == '0) begin
      last_idx = '0;
    end else if (int'(cfg_entries_q) > int'(PALETTE_DEPTH)) begin
      last_idx = IDX_W'(PALETTE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(cfg_entries_q - CFG_W'(1));
    end
  end

  // Palette load and scan read
  assign load_idx = IDX_W'(in_slot);
  assign load_we  = in_fire && (s_axis_tuser == REQ_LOAD) &&
                    (int'(in_slot) < int'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[load_idx] <= in_color;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  // Distance of the entry just read
  nupm_dist u_dist (
    .color_i (rd_data_q),
    .red_i   (pix_red_q),
    .green_i (pix_green_q),
    .blue_i  (pix_blue_q),
    .dist_o  (entry_dist)
  );

  // Best candidate updates; first smaller distance wins so ties keep the lowest slot
  assign take_free = s2_valid_q && !s2_used_q && (!found_free_q || (s2_dist_q < free_dist_q));
  assign take_all  = s2_valid_q && (!found_all_q || (s2_dist_q < all_dist_q));

  // Commit choice: with no unused entry, all marks drop and the overall best wins
  assign wrapped    = !found_free_q;
  assign pick_idx   = wrapped ? all_idx_q : free_idx_q;
  assign pick_color = wrapped ? all_color_q : free_color_q;
  assign commit     = (state_q == ST_FINISH) && out_free;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    s1_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_idx_d = '0;
        if (in_fire && (s_axis_tuser == REQ_MATCH)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        s1_valid_d = 1'b1;
        if (rd_idx_q == last_idx_q) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (s2_valid_q && s2_last_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Used marks: clear request, wrap and commit
  always_comb begin
    used_d = used_q;
    if (in_fire && (s_axis_tuser == REQ_CLEAR)) begin
      used_d = '0;
    end
    if (commit) begin
      if (wrapped) begin
        used_d = '0;
      end
      used_d[pick_idx] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cfg_entries_q <= CFG_W'(64);
      used_q        <= '0;
      rd_idx_q      <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      found_free_q  <= 1'b0;
      found_all_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      rd_idx_q   <= rd_idx_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      if (cfg_wr_en_i) begin
        cfg_entries_q <= cfg_wr_data_i;
      end
      // Restart the search on each accepted request
      if (in_fire) begin
        found_free_q <= 1'b0;
        found_all_q  <= 1'b0;
      end else begin
        if (take_free) begin
          found_free_q <= 1'b1;
        end
        if (take_all) begin
          found_all_q <= 1'b1;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_red_q   <= in_red;
      pix_green_q <= in_green;
      pix_blue_q  <= in_blue;
      last_idx_q  <= last_idx;
    end
    s1_idx_q   <= rd_idx_q;
    s1_used_q  <= used_q[rd_idx_q];
    s1_last_q  <= (rd_idx_q == last_idx_q);
    s2_idx_q   <= s1_idx_q;
    s2_used_q  <= s1_used_q;
    s2_last_q  <= s1_last_q;
    s2_color_q <= rd_data_q;
    s2_dist_q  <= entry_dist;
    if (take_free) begin
      free_dist_q  <= s2_dist_q;
      free_idx_q   <= s2_idx_q;
      free_color_q <= s2_color_q;
    end
    if (take_all) begin
      all_dist_q  <= s2_dist_q;
      all_idx_q   <= s2_idx_q;
      all_color_q <= s2_color_q;
    end
    if (commit) begin
      out_color_q <= pick_color;
      out_idx_q   <= SLOT_W'(pick_idx);
      out_wrap_q  <= wrapped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_idx_q, out_color_q};
  assign m_axis_tuser  = out_wrap_q;

endmodule

`default_nettype wire

/* src/nupm_dist.sv */
// ----------------------------------------------------------------------------
// nupm_dist: squared RGB distance
// Sum of the squared per-channel differences between a palette color
// (0xRRGGBB) and an 8-bit pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module nupm_dist
  import nupm_pkg::*;
(
  input  wire color_t              color_i,
  input  wire logic [CHAN_W-1:0]   red_i,
  input  wire logic [CHAN_W-1:0]   green_i,
  input  wire logic [CHAN_W-1:0]   blue_i,
  output dist_t                    dist_o
);

  logic [CHAN_W-1:0]   cr, cg, cb;
  logic [CHAN_W-1:0]   dr, dg, db;
  logic [2*CHAN_W-1:0] sr, sg, sb;

  // Split the color into channels
  assign cr = color_i[23:16];
  assign cg = color_i[15:8];
  assign cb = color_i[7:0];

  // Absolute differences
  assign dr = (cr >= red_i)   ? (cr - red_i)   : (red_i - cr);
  assign dg = (cg >= green_i) ? (cg - green_i) : (green_i - cg);
  assign db = (cb >= blue_i)  ? (cb - blue_i)  : (blue_i - cb);

  // Squares and sum
  assign sr = (2*CHAN_W)'(dr) * (2*CHAN_W)'(dr);
  assign sg = (2*CHAN_W)'(dg) * (2*CHAN_W)'(dg);
  assign sb = (2*CHAN_W)'(db) * (2*CHAN_W)'(db);

  assign dist_o = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);

endmodule

`default_nettype wire

/* src/nupm_checker.sv */
// ----------------------------------------------------------------------------
// nupm_checker: port-level checks for the nearest unused palette match
// Watches the stream ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module nupm_checker
  import nupm_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [1:0]            s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // Waiting request holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("waiting request changed");

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A match occupies the block: no request taken in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_MATCH) |=> !s_axis_tready)
    else $error("request accepted during a match scan");

  // Loads, clears and unknown requests never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_MATCH) |=>
      !(m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)))
    else $error("result produced for a non-match request");

  // Returned slot lies inside the palette
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tdata[29:24]) < int'(PALETTE_DEPTH)))
    else $error("result slot outside the palette");

endmodule

bind nearest_unused_palette_match nupm_checker #(
  .PALETTE_DEPTH (PALETTE_DEPTH)
) u_nupm_checker (.*);

`default_nettype wire

/* tb/nearest_unused_palette_match_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_unused_palette_match_tb: self-checking bench for the palette match
// Streams load, match, clear and unknown requests into the block under bursty
// traffic and a stalling receiver. A scoreboard tracks the palette, the used
// marks and the slot count and checks every match transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_unused_palette_match_tb;
  import nupm_pkg::*;

  localparam int unsigned DEPTH         = 64;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;

  typedef struct packed {
    color_t             color;
    logic [SLOT_W-1:0]  slot;
    logic               wrapped;
  } match_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: palette predictor and queue of expected match results
  // --------------------------------------------------------------------------
  class palette_scoreboard;
    color_t            palette [DEPTH];
    bit                used [DEPTH];
    bit                loaded [DEPTH];
    logic [CFG_W-1:0]  entries_reg;
    match_result_t     pending [$];
    int                errors;
    int                n_loads;
    int                n_matches;
    int                n_wraps;
    int                n_clears;
    int                n_ignored;

    function new();
      entries_reg = CFG_W'(DEPTH);
      foreach (used[i]) begin
        used[i]    = 1'b0;
        loaded[i]  = 1'b0;
        palette[i] = '0;
      end
      errors    = 0;
      n_loads   = 0;
      n_matches = 0;
      n_wraps   = 0;
      n_clears  = 0;
      n_ignored = 0;
    endfunction

    // Clamp the register to 1..DEPTH
    function int unsigned active_slots();
      if (entries_reg == 0) return 1;
      if (entries_reg > DEPTH) return DEPTH;
      return entries_reg;
    endfunction

    // True when every slot a match would scan holds a loaded color
    function bit palette_ready();
      for (int i = 0; i < active_slots(); i++)
        if (!loaded[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_entries(logic [CFG_W-1:0] value);
      entries_reg = value;
    endfunction

    function dist_t chan_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? a - b : b - a;
      return dist_t'(d) * dist_t'(d);
    endfunction

    // Update the palette state for one accepted request
    function void note_request(logic [1:0] req, logic [IN_DATA_W-1:0] data);
      int unsigned    n;
      int unsigned    best;
      dist_t          best_dist;
      dist_t          d;
      bit             found;
      bit             any_free;
      color_t         c;
      match_result_t  r;
      n = active_slots();
      case (req)
        REQ_LOAD: begin
          palette[data[5:0]] = data[29:6];
          loaded[data[5:0]]  = 1'b1;
          n_loads++;
        end
        REQ_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
          n_clears++;
        end
        REQ_MATCH: begin
          any_free = 1'b0;
          for (int i = 0; i < n; i++)
            if (!used[i]) any_free = 1'b1;
          if (!any_free) begin
            foreach (used[i]) used[i] = 1'b0;
            n_wraps++;
          end
          found     = 1'b0;
          best      = 0;
          best_dist = '0;
          for (int i = 0; i < n; i++) begin
            if (used[i]) continue;
            c = palette[i];
            d = chan_sq(c[23:16], data[37:30]) + chan_sq(c[15:8], data[45:38])
              + chan_sq(c[7:0], data[53:46]);
            if (!found || d < best_dist) begin
              found     = 1'b1;
              best_dist = d;
              best      = i;
            end
          end
          used[best] = 1'b1;
          r.color    = palette[best];
          r.slot     = SLOT_W'(best);
          r.wrapped  = !any_free;
          pending.push_back(r);
          n_matches++;
        end
        default: n_ignored++;
      endcase
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] data, logic wrapped);
      match_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: tdata %08h, tuser %0b", data, wrapped);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (data[23:0] !== r.color) begin
        $error("match_color mismatch: expected %06h, got %06h", r.color, data[23:0]);
        errors++;
      end
      if (data[29:24] !== r.slot) begin
        $error("match_index mismatch: expected %0d, got %0d", r.slot, data[29:24]);
        errors++;
      end
      if (wrapped !== r.wrapped) begin
        $error("marks_wrapped mismatch: expected %0b, got %0b", r.wrapped, wrapped);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data   = '0;
  logic                   s_tvalid      = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata       = '0;
  logic [1:0]             s_tuser       = '0;
  logic                   m_tvalid;
  logic                   m_tready      = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;

  palette_scoreboard sb = new();
  int  burst_left    = 0;
  bit  hold_off_req  = 1'b0;
  int  idle_cycles   = 0;
  int  n_settings    = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  nearest_unused_palette_match #(
    .PALETTE_DEPTH (DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  // --------------------------------------------------------------------------
  // Result monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: segments of steady, random, toggling and sparse ready
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned seg_len;
    forever begin
      if (hold_off_req) begin
        m_tready     <= 1'b0;
        hold_off_req  = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(1, 60);
        for (int k = 0; k < seg_len && !hold_off_req; k++) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= k[0];
            default: m_tready <= (k % 4 == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] pack_req(logic [SLOT_W-1:0] slot, color_t color,
                                                   logic [7:0] red, logic [7:0] green,
                                                   logic [7:0] blue);
    return {2'b00, blue, green, red, color, slot};
  endfunction

  // Offer one transaction in bursts with random gaps; hold until accepted
  task automatic send_item(logic [1:0] req, logic [IN_DATA_W-1:0] data);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= req;
    do @(posedge clk_i); while (!s_tready);
    sb.note_request(req, data);
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic load_item(logic [SLOT_W-1:0] slot, color_t color);
    send_item(REQ_LOAD, pack_req(slot, color, 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic match_item(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    send_item(REQ_MATCH, pack_req(6'($urandom), 24'($urandom), red, green, blue));
  endtask

  task automatic other_item(logic [1:0] req);
    send_item(req, pack_req(6'($urandom), 24'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom)));
  endtask

  // Stop offering, wait for every expected result, then let the block settle
  task automatic drain_results();
    if (burst_left != 0) begin
      s_tvalid   <= 1'b0;
      burst_left  = 0;
    end
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the slot count; only called while the block is idle
  task automatic write_entries(logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
    sb.set_entries(value);
    n_settings++;
  endtask

  // One random request; loads fill the active range before any match
  task automatic send_random_item();
    int unsigned       roll;
    int unsigned       n;
    int unsigned       j;
    logic [SLOT_W-1:0] slot;
    color_t            color;
    roll = $urandom_range(0, 99);
    n    = sb.active_slots();
    if (roll < 4) begin
      other_item(REQ_UNUSED);
    end else if (roll < 10) begin
      other_item(REQ_CLEAR);
    end else if (roll < 35 || !sb.palette_ready()) begin
      slot = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, n - 1)) : 6'($urandom);
      for (int i = n - 1; i >= 0; i--)
        if (!sb.loaded[i]) slot = SLOT_W'(i);
      roll  = $urandom_range(0, 99);
      color = 24'($urandom);
      if (roll < 10) begin
        color = (roll < 5) ? 24'h000000 : 24'hFFFFFF;
      end else if (roll < 35) begin
        // Copy an existing color to provoke distance ties
        for (int t = 0; t < 8; t++) begin
          j = $urandom_range(0, DEPTH - 1);
          if (sb.loaded[j]) color = sb.palette[j];
        end
      end
      load_item(slot, color);
    end else begin
      roll  = $urandom_range(0, 99);
      color = 24'($urandom);
      if (roll < 10) begin
        color = (roll < 5) ? 24'h000000 : 24'hFFFFFF;
      end else if (roll < 40) begin
        color = sb.palette[$urandom_range(0, n - 1)];
      end
      match_item(color[23:16], color[15:8], color[7:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] setting [10];
    setting = '{7'd64, 7'd127, 7'd8, 7'd1, 7'd0, 7'd33, 7'd64, 7'd100, 7'd2, 7'd64};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero slots act as one: match, wrap on a full palette, ignore, clear
    write_entries(7'd0);
    load_item(6'd0, 24'h000000);
    match_item(8'd0, 8'd0, 8'd0);
    match_item(8'd255, 8'd255, 8'd255);
    other_item(REQ_UNUSED);
    other_item(REQ_CLEAR);
    match_item(8'd255, 8'd0, 8'd255);
    drain_results();

    // Four slots: ties go to the lowest slot, reload keeps the mark
    write_entries(7'd4);
    load_item(6'd1, 24'hFFFFFF);
    load_item(6'd2, 24'h808080);
    load_item(6'd3, 24'h808080);
    load_item(6'd63, 24'h123456);
    load_item(6'd0, 24'hFF0000);
    match_item(8'd128, 8'd128, 8'd128);
    match_item(8'd128, 8'd128, 8'd128);
    match_item(8'd255, 8'd0, 8'd0);
    match_item(8'd0, 8'd0, 8'd0);
    drain_results();

    // Shrink to two slots: marks above stay but are not scanned
    write_entries(7'd2);
    match_item(8'd128, 8'd128, 8'd128);
    match_item(8'd0, 8'd0, 8'd0);
    match_item(8'd255, 8'd255, 8'd255);
    other_item(REQ_CLEAR);
    match_item(8'd255, 8'd255, 8'd255);
    drain_results();

    // Random phases over several slot counts, one with a long receiver hold
    foreach (setting[p]) begin
      write_entries(setting[p]);
      for (int k = 0; k < 70; k++) begin
        if (p == 1 && k == 10) hold_off_req = 1'b1;
        send_random_item();
      end
      drain_results();
    end

    $display("covered %0d loads, %0d matches (%0d after a wrap), %0d clears, %0d unknown",
             sb.n_loads, sb.n_matches, sb.n_wraps, sb.n_clears, sb.n_ignored);
    $display("across %0d slot count settings including 0, 1, 64 and 127", n_settings);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.pending.size() != 0)
        $error("%0d expected results never arrived", sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
